// ===== hw/rtl/lw53_pkg.sv =====
// shared types and constants of the 5/3 lifting wavelet
`default_nettype none

package lw53_pkg;

  // fixed field widths
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned BAND_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // most results that one item can cause
  localparam int unsigned RES_MAX   = 3;
  localparam int unsigned RES_CNT_W = 2;

  // result queue geometry
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_PTR_W = 3;
  localparam int unsigned RQ_CNT_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LENGTH = 1'b1;

  // reset value of the signal length
  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  // band codes
  localparam logic [BAND_W-1:0] BAND_LOW    = 2'd0;
  localparam logic [BAND_W-1:0] BAND_HIGH   = 2'd1;
  localparam logic [BAND_W-1:0] BAND_SAMPLE = 2'd2;

  typedef enum logic {
    DIR_ANALYSIS  = 1'b0,
    DIR_SYNTHESIS = 1'b1
  } dir_e;

  // per-result side information
  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [POS_W-1:0]  position;
    logic              final_res;
  } res_tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lw53_in_if.sv =====
// input channel: one sample or coefficient per transaction
`default_nettype none

interface lw53_in_if #(
  parameter int unsigned VALUE_BITS = 18
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lw53_out_if.sv =====
// result channel: one coefficient or sample per transaction
`default_nettype none

interface lw53_out_if #(
  parameter int unsigned VALUE_BITS = 18
);
  logic                               valid;
  logic                               ready;
  logic signed [VALUE_BITS-1:0]       result_value;
  logic [lw53_pkg::BAND_W-1:0]        band;
  logic [lw53_pkg::POS_W-1:0]         position;
  logic                               final_res;

  modport source (output valid, output result_value, output band, output position,
                  output final_res, input ready);
  modport sink   (input valid, input result_value, input band, input position,
                  input final_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lw53_cfg_if.sv =====
// configuration write channel
`default_nettype none

interface lw53_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lw53_pkg::CFG_IDX_W-1:0]    index;
  logic [lw53_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lw53_core.sv =====
// input register, lifting state and single-pass lifting arithmetic
`default_nettype none

module lw53_core #(
  parameter int unsigned VALUE_BITS = 18,
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  lw53_cfg_if.sink                 cfg_i,
  lw53_in_if.sink                  in_i,
  input  wire logic                room_i,
  output logic [lw53_pkg::RES_CNT_W-1:0]                     push_cnt_o,
  output logic [lw53_pkg::RES_MAX-1:0][VALUE_BITS-1:0]       push_val_o,
  output lw53_pkg::res_tag_t [lw53_pkg::RES_MAX-1:0]         push_tag_o
);

  localparam int unsigned VB = VALUE_BITS;
  // held state width: values carried across a direction change can grow to about 4x
  localparam int unsigned SW = VALUE_BITS + 3;
  localparam int unsigned CW = VALUE_BITS + 4;   // working width
  localparam int unsigned LEN_W = lw53_pkg::LEN_W;
  localparam int unsigned CNT_W = lw53_pkg::CNT_W;
  localparam int unsigned POS_W = lw53_pkg::POS_W;
  localparam int unsigned LEN_CAP = (MAX_LENGTH > 8191) ? 8191 : MAX_LENGTH;
  localparam logic [LEN_W-1:0] LEN_CAP_L = LEN_W'(LEN_CAP);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic signed [CW-1:0] SAT_HI = {{(CW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_LO = {{(CW-VB+1){1'b1}}, {(VB-1){1'b0}}};

  // divide by two, truncating toward zero
  function automatic logic signed [CW-1:0] div2(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] t;
    t = x + {{(CW-1){1'b0}}, x[CW-1]};
    return t >>> 1;
  endfunction

  // divide by four, truncating toward zero
  function automatic logic signed [CW-1:0] div4(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] t;
    t = x + {{(CW-2){1'b0}}, x[CW-1], x[CW-1]};
    return t >>> 2;
  endfunction

  // clamp to the signed result range
  function automatic logic [VB-1:0] sat(input logic signed [CW-1:0] x);
    logic [VB-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[VB-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[VB-1:0];
    end else begin
      r = x[VB-1:0];
    end
    return r;
  endfunction

  // configuration registers
  lw53_pkg::dir_e     dir_q;
  logic [LEN_W-1:0]   len_q;

  // input register
  logic               inq_valid_q;
  logic [VB-1:0]      inq_value_q;

  // lifting state
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SW-1:0]      held_even_q, held_even_d;
  logic [SW-1:0]      held_odd_q, held_odd_d;
  logic [SW-1:0]      prev_high_q, prev_high_d;
  logic [SW-1:0]      pend_low_q, pend_low_d;

  logic               fire;
  logic [LEN_W-1:0]   n_eff;
  logic               last;
  logic [POS_W-1:0]   half_idx;
  logic [POS_W-1:0]   k_low;
  logic               low_first;

  logic signed [CW-1:0] v_x, he_x, ho_x, ph_x, pl_x;
  logic signed [CW-1:0] a_h_even, a_h, a_l, a_edge;
  logic signed [CW-1:0] s_se, s_so, s_last, s_end, s_sodd;

  logic [lw53_pkg::RES_CNT_W-1:0]               res_cnt;
  logic [lw53_pkg::RES_MAX-1:0][VB-1:0]         res_val;
  lw53_pkg::res_tag_t [lw53_pkg::RES_MAX-1:0]   res_tag;

  assign cfg_i.ready = 1'b1;
  assign fire        = inq_valid_q && room_i;
  assign in_i.ready  = !inq_valid_q || fire;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= lw53_pkg::DIR_ANALYSIS;
      len_q <= lw53_pkg::LEN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lw53_pkg::CFG_DIRECTION:     dir_q <= lw53_pkg::dir_e'(cfg_i.data[0]);
        lw53_pkg::CFG_SIGNAL_LENGTH: len_q <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      inq_value_q <= in_i.value;
    end
  end

  // effective length and position bookkeeping
  always_comb begin
    if (len_q < LEN_MIN) begin
      n_eff = LEN_MIN;
    end else if (len_q > LEN_CAP_L) begin
      n_eff = LEN_CAP_L;
    end else begin
      n_eff = len_q;
    end
    last      = (count_q >= (n_eff - LEN_W'(1)));
    half_idx  = count_q[CNT_W-1:1];
    k_low     = count_q[POS_W-1:0];
    low_first = count_q[0] ? (half_idx == '0) : (half_idx == POS_W'(1));
  end

  // lifting arithmetic on the widened operands
  always_comb begin
    v_x  = {{(CW-VB){inq_value_q[VB-1]}}, inq_value_q};
    he_x = {{(CW-SW){held_even_q[SW-1]}}, held_even_q};
    ho_x = {{(CW-SW){held_odd_q[SW-1]}}, held_odd_q};
    ph_x = {{(CW-SW){prev_high_q[SW-1]}}, prev_high_q};
    pl_x = {{(CW-SW){pend_low_q[SW-1]}}, pend_low_q};

    // analysis predict and update
    a_h_even = ho_x - div2(he_x + v_x);
    a_h      = count_q[0] ? (v_x - he_x) : a_h_even;
    a_l      = low_first ? (he_x + div2(a_h)) : (he_x + div4(a_h + ph_x));
    a_edge   = v_x + div2(a_h_even);

    // synthesis inverse steps
    s_se   = (half_idx == '0) ? (pl_x - div2(v_x)) : (pl_x - div4(v_x + ph_x));
    s_so   = ph_x + div2(he_x + s_se);
    s_last = v_x + s_se;
    s_end  = v_x - div2(ph_x);
    s_sodd = ph_x + div2(he_x + s_end);
  end

  // result selection and next state
  always_comb begin
    res_cnt     = '0;
    res_val     = '0;
    res_tag     = '0;
    held_even_d = held_even_q;
    held_odd_d  = held_odd_q;
    prev_high_d = prev_high_q;
    pend_low_d  = pend_low_q;
    count_d     = last ? '0 : count_q + CNT_W'(1);

    if (dir_q == lw53_pkg::DIR_ANALYSIS) begin
      if (!count_q[0]) begin
        held_even_d = v_x[SW-1:0];
        if (count_q != '0) begin
          res_val[0] = sat(a_l);
          res_tag[0] = '{band: lw53_pkg::BAND_LOW, position: half_idx - POS_W'(1),
                         final_res: 1'b0};
          res_val[1] = sat(a_h);
          res_tag[1] = '{band: lw53_pkg::BAND_HIGH, position: half_idx - POS_W'(1),
                         final_res: 1'b0};
          prev_high_d = a_h[SW-1:0];
          res_cnt     = 2'd2;
          if (last) begin
            res_val[2] = sat(a_edge);
            res_tag[2] = '{band: lw53_pkg::BAND_LOW, position: half_idx, final_res: 1'b1};
            res_cnt    = 2'd3;
          end
        end
      end else begin
        held_odd_d = v_x[SW-1:0];
        if (last) begin
          res_val[0]  = sat(a_l);
          res_tag[0]  = '{band: lw53_pkg::BAND_LOW, position: half_idx, final_res: 1'b0};
          res_val[1]  = sat(a_h);
          res_tag[1]  = '{band: lw53_pkg::BAND_HIGH, position: half_idx, final_res: 1'b1};
          prev_high_d = a_h[SW-1:0];
          res_cnt     = 2'd2;
        end
      end
    end else begin
      if (!count_q[0]) begin
        pend_low_d = v_x[SW-1:0];
        // odd-length edge: closing low coefficient
        if (last && (count_q >= CNT_W'(2))) begin
          res_val[0]  = sat(s_sodd);
          res_tag[0]  = '{band: lw53_pkg::BAND_SAMPLE, position: k_low - POS_W'(1),
                          final_res: 1'b0};
          res_val[1]  = sat(s_end);
          res_tag[1]  = '{band: lw53_pkg::BAND_SAMPLE, position: k_low, final_res: 1'b1};
          held_even_d = s_end[SW-1:0];
          res_cnt     = 2'd2;
        end
      end else begin
        // k is odd: 2i = k-1, 2i-1 = k-2, 2i+1 = k
        if (half_idx != '0) begin
          res_val[0] = sat(s_so);
          res_tag[0] = '{band: lw53_pkg::BAND_SAMPLE, position: k_low - POS_W'(2),
                         final_res: 1'b0};
          res_val[1] = sat(s_se);
          res_tag[1] = '{band: lw53_pkg::BAND_SAMPLE, position: k_low - POS_W'(1),
                         final_res: 1'b0};
          res_cnt    = 2'd2;
          if (last) begin
            res_val[2] = sat(s_last);
            res_tag[2] = '{band: lw53_pkg::BAND_SAMPLE, position: k_low, final_res: 1'b1};
            res_cnt    = 2'd3;
          end
        end else begin
          res_val[0] = sat(s_se);
          res_tag[0] = '{band: lw53_pkg::BAND_SAMPLE, position: k_low - POS_W'(1),
                         final_res: 1'b0};
          res_cnt    = 2'd1;
          if (last) begin
            res_val[1] = sat(s_last);
            res_tag[1] = '{band: lw53_pkg::BAND_SAMPLE, position: k_low, final_res: 1'b1};
            res_cnt    = 2'd2;
          end
        end
        held_even_d = s_se[SW-1:0];
        prev_high_d = v_x[SW-1:0];
      end
    end
  end

  // lifting state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      held_even_q <= '0;
      held_odd_q  <= '0;
      prev_high_q <= '0;
      pend_low_q  <= '0;
    end else if (fire) begin
      count_q     <= count_d;
      held_even_q <= held_even_d;
      held_odd_q  <= held_odd_d;
      prev_high_q <= prev_high_d;
      pend_low_q  <= pend_low_d;
    end
  end

  assign push_cnt_o = fire ? res_cnt : '0;
  assign push_val_o = res_val;
  assign push_tag_o = res_tag;

endmodule

`default_nettype wire

// ===== hw/rtl/lw53_rq.sv =====
// result queue: takes up to three results a cycle, hands out one while the result channel is ready
`default_nettype none

module lw53_rq #(
  parameter int unsigned VALUE_BITS = 18
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic [lw53_pkg::RES_CNT_W-1:0]                push_cnt_i,
  input  wire logic [lw53_pkg::RES_MAX-1:0][VALUE_BITS-1:0]  push_val_i,
  input  wire lw53_pkg::res_tag_t [lw53_pkg::RES_MAX-1:0]    push_tag_i,
  output logic                                               room_o,
  lw53_out_if.source                                         out_o
);

  localparam int unsigned PTR_W = lw53_pkg::RQ_PTR_W;
  localparam int unsigned CNT_W = lw53_pkg::RQ_CNT_W;
  localparam int unsigned DEPTH = lw53_pkg::RQ_DEPTH;
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - lw53_pkg::RES_MAX);

  logic [VALUE_BITS-1:0]  val_q [DEPTH];
  lw53_pkg::res_tag_t     tag_q [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       count_q;
  logic                   pop;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (count_q <= ROOM_LIMIT);

  // entry storage
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < int'(lw53_pkg::RES_MAX); e++) begin
      if (e < int'(push_cnt_i)) begin
        val_q[wr_ptr_q + PTR_W'(e)] <= push_val_i[e];
        tag_q[wr_ptr_q + PTR_W'(e)] <= push_tag_i[e];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + CNT_W'(push_cnt_i) - CNT_W'(pop);
    end
  end

  // head of queue drives the result channel
  assign out_o.valid        = (count_q != '0);
  assign out_o.result_value = val_q[rd_ptr_q];
  assign out_o.band         = tag_q[rd_ptr_q].band;
  assign out_o.position     = tag_q[rd_ptr_q].position;
  assign out_o.final_res    = tag_q[rd_ptr_q].final_res;

endmodule

`default_nettype wire

// ===== hw/rtl/lifting_53_wavelet.sv =====
// one-level 5/3 lifting wavelet, analysis or synthesis over a stream
// each result passes the input register and then the result queue on its way to the output
// throughput: one input transaction per cycle; each item puts at most three results into an
//   eight-entry queue that drains one per cycle, so input waits only while fewer than three
//   entries are free, which needs a result side slower than one transaction per cycle
// reset clears the configuration to analysis with length 4096 and restarts the signal
`default_nettype none

module lifting_53_wavelet #(
  parameter int unsigned MAX_LENGTH = 4096,
  parameter int unsigned VALUE_BITS = 18
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lw53_cfg_if.sink      cfg_i,
  lw53_in_if.sink       in_i,
  lw53_out_if.source    out_o
);

  logic                                                 room;
  logic [lw53_pkg::RES_CNT_W-1:0]                       push_cnt;
  logic [lw53_pkg::RES_MAX-1:0][VALUE_BITS-1:0]         push_val;
  lw53_pkg::res_tag_t [lw53_pkg::RES_MAX-1:0]           push_tag;

  // lifting stage
  lw53_core #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .in_i       (in_i),
    .room_i     (room),
    .push_cnt_o (push_cnt),
    .push_val_o (push_val),
    .push_tag_o (push_tag)
  );

  // result queue
  lw53_rq #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_val_i (push_val),
    .push_tag_i (push_tag),
    .room_o     (room),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
